/* src/sdce_pkg.sv */
// Shared types, codes and the CRC-7 column table for the SD SPI command engine.
// No dependencies; imported by every other module of the block.
`default_nettype none

package sdce_pkg;

    localparam int FRAME_LEN   = 7;
    localparam int CRC_BITS    = 40;
    localparam logic [7:0] FILL_BYTE  = 8'hFF;
    localparam logic [1:0] START_BITS = 2'b01;
    localparam logic [7:0] RESP_BUSY  = 8'h80;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_TIMEOUT = 1'b1;

    localparam logic ACT_START   = 1'b0;
    localparam logic ACT_RECEIVE = 1'b1;

    localparam logic CFG_RESP_LIMIT = 1'b0;
    localparam logic CFG_BUSY_LIMIT = 1'b1;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_DISCARD,
        PH_POLL,
        PH_COLLECT,
        PH_BUSY
    } t_phase;

    typedef enum logic [1:0] {
        KIND_SEND,
        KIND_CONSUMED,
        KIND_RESPONSE,
        KIND_DONE
    } t_kind;

    typedef struct packed {
        logic [7:0]  received_byte;
        logic        busy_wait;
        logic [7:0]  match_byte;
        logic        match_enable;
        logic [3:0]  response_length;
        logic [31:0] cmd_argument;
        logic [5:0]  cmd_index;
        logic        action;
    } t_item;

    typedef struct packed {
        logic       last;
        logic       status;
        logic [2:0] pos;
        logic [7:0] data;
        t_kind      kind;
    } t_result;

    function automatic t_result mk_result(t_kind kind, logic [7:0] data, logic [2:0] pos,
                                          logic status, logic last);
        t_result r;
        r.kind   = kind;
        r.data   = data;
        r.pos    = pos;
        r.status = status;
        r.last   = last;
        return r;
    endfunction

    // CRC-7 (x^7 + x^3 + 1, zero start) is linear: column k is the CRC of the
    // 40-bit message with only bit k set. Evaluated at elaboration only.
    function automatic logic [CRC_BITS-1:0][6:0] crc7_cols();
        logic [CRC_BITS-1:0][6:0] cols;
        logic [6:0] crc;
        logic       top;
        for (int k = 0; k < CRC_BITS; k++) begin
            crc = '0;
            for (int b = CRC_BITS - 1; b >= 0; b--) begin
                top = crc[6] ^ (b == k);
                crc = {crc[5:0], 1'b0};
                if (top) begin
                    crc = crc ^ 7'h09;
                end
            end
            cols[k] = crc;
        end
        return cols;
    endfunction

    localparam logic [CRC_BITS-1:0][6:0] CRC7_COLS = crc7_cols();

endpackage

`default_nettype wire

/* src/sd_spi_command_engine.sv */
// Top level of the SD-card SPI-mode command engine: input register, config registers,
// and the engine and result register. Depends on sdce_pkg, sdce_engine, sdce_burst.
//
//  channel  | dir | handshake                  | payload
//  ---------+-----+----------------------------+------------------------------------
//  s stream | in  | i_s_tvalid / o_s_tready    | tdata command or received byte, tuser action
//  m stream | out | o_m_tvalid / i_m_tready    | tdata result, tuser kind, tlast
//  config   | in  | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data (16 bit)
//
// An item is registered on accept; the engine evaluates it combinationally and its
// results (none to 7) load into the result register once that register is free.
// The result register sends one word per cycle while i_m_tready is high, and a
// new item's results load as the last word of the previous item goes out, so
// single-result items flow at one per cycle while the output does not stall.
// The input register refills while results wait, so a stalled output holds
// one item in flight plus the one at the input. Reset is synchronous, active
// low, and clears the phase, counters and valid flags; config resets to 8/32000.
`default_nettype none

module sd_spi_command_engine
    import sdce_pkg::*;
#(
    parameter int MAX_RESPONSE = 8
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // slave stream
    input  wire logic         i_s_tvalid,
    output logic              o_s_tready,
    // [5:0] cmd_index, [37:6] cmd_argument, [41:38] response_length,
    // [42] match_enable, [50:43] match_byte, [51] busy_wait,
    // [59:52] received_byte, [63:60] zero
    input  wire logic [63:0]  i_s_tdata,
    // [0] action
    input  wire logic         i_s_tuser,
    // master stream
    output logic              o_m_tvalid,
    input  wire logic         i_m_tready,
    // [7:0] data, [10:8] byte_position, [11] status, [15:12] zero
    output logic [15:0]       o_m_tdata,
    // [1:0] kind
    output logic [1:0]        o_m_tuser,
    output logic              o_m_tlast,
    // config write
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic         i_cfg_index,
    input  wire logic [15:0]  i_cfg_data
);

    logic                     r_in_valid;
    t_item                    r_item;
    logic [15:0]              r_resp_limit;
    logic [15:0]              r_busy_limit;

    logic                     advance;
    logic                     burst_free;
    t_result [FRAME_LEN-1:0]  res;
    logic [2:0]               res_cnt;
    t_result                  out_res;

    // item leaves the input register when the result register can take its results
    assign advance     = r_in_valid && burst_free;
    assign o_s_tready  = !r_in_valid || burst_free;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_item <= {i_s_tdata[59:0], i_s_tuser};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_resp_limit <= 16'd8;
            r_busy_limit <= 16'd32000;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_RESP_LIMIT: r_resp_limit <= i_cfg_data;
                CFG_BUSY_LIMIT: r_busy_limit <= i_cfg_data;
                default:        r_resp_limit <= r_resp_limit;
            endcase
        end
    end

    sdce_engine #(
        .MAX_RESPONSE (MAX_RESPONSE)
    ) u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_advance    (advance),
        .i_item       (r_item),
        .i_resp_limit (r_resp_limit),
        .i_busy_limit (r_busy_limit),
        .o_res        (res),
        .o_res_cnt    (res_cnt)
    );

    sdce_burst u_burst (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (advance),
        .i_res     (res),
        .i_res_cnt (res_cnt),
        .i_ready   (i_m_tready),
        .o_valid   (o_m_tvalid),
        .o_res     (out_res),
        .o_free    (burst_free)
    );

    assign o_m_tdata = {4'd0, out_res.status, out_res.pos, out_res.data};
    assign o_m_tuser = out_res.kind;
    assign o_m_tlast = out_res.last;

endmodule

`default_nettype wire

/* src/sdce_engine.sv */
// Command state machine: phase and counters, plus the results of one item.
// Depends on sdce_pkg.
`default_nettype none

module sdce_engine
    import sdce_pkg::*;
#(
    parameter int MAX_RESPONSE = 8
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_advance,
    input  wire t_item                     i_item,
    input  wire logic [15:0]               i_resp_limit,
    input  wire logic [15:0]               i_busy_limit,
    output t_result [FRAME_LEN-1:0]        o_res,
    output logic [2:0]                     o_res_cnt
);

    localparam int CW = $clog2(MAX_RESPONSE + 1);

    t_phase          r_phase, n_phase;
    logic [15:0]     r_poll_count, n_poll_count;
    logic [CW-1:0]   r_collected, n_collected;
    logic [CW-1:0]   r_want, n_want;
    logic            r_match_mode, n_match_mode;
    logic [7:0]      r_match_value, n_match_value;
    logic            r_busy_mode, n_busy_mode;

    logic [7:0]      rx;
    logic [CW-1:0]   sat_len;
    logic            len_zero;
    logic [15:0]     resp_lim;
    logic [16:0]     poll_inc;
    logic            resp_expired;
    logic            busy_expired;
    logic            hit;
    logic [CW:0]     coll_inc;
    logic            first_done;
    logic            coll_done;
    logic            busy_zero;
    logic            ar_emit;
    logic [39:0]     msg;
    logic [6:0]      crc;

    assign rx       = i_item.received_byte;
    assign sat_len  = (int'(i_item.response_length) > MAX_RESPONSE) ? CW'(MAX_RESPONSE)
                    : CW'(i_item.response_length);
    assign len_zero = (i_item.response_length == 4'd0);
    assign resp_lim = (i_resp_limit == 16'd0) ? 16'd1 : i_resp_limit;
    assign poll_inc = {1'b0, r_poll_count} + 17'd1;
    assign resp_expired = (poll_inc >= {1'b0, resp_lim});
    assign busy_expired = (poll_inc >= {1'b0, i_busy_limit});
    assign hit = r_match_mode ? (rx == r_match_value) : ((rx & RESP_BUSY) == 8'd0);
    assign coll_inc   = {1'b0, r_collected} + (CW + 1)'(1);
    assign first_done = ({1'b0, r_want} <= (CW + 1)'(1));
    assign coll_done  = (coll_inc >= {1'b0, r_want});
    assign busy_zero  = (i_busy_limit == 16'd0);
    // after the last response byte a done result follows unless a busy wait starts
    assign ar_emit    = !r_busy_mode || busy_zero;

    assign msg = {START_BITS, i_item.cmd_index, i_item.cmd_argument};

    always_comb begin
        crc = '0;
        for (int k = 0; k < CRC_BITS; k++) begin
            if (msg[k]) begin
                crc = crc ^ CRC7_COLS[k];
            end
        end
    end

    // next state
    always_comb begin
        n_phase       = r_phase;
        n_poll_count  = r_poll_count;
        n_collected   = r_collected;
        n_want        = r_want;
        n_match_mode  = r_match_mode;
        n_match_value = r_match_value;
        n_busy_mode   = r_busy_mode;
        if (i_item.action == ACT_START) begin
            if (len_zero) begin
                n_phase = PH_IDLE;
            end else begin
                n_phase       = PH_DISCARD;
                n_want        = sat_len;
                n_match_mode  = i_item.match_enable;
                n_match_value = i_item.match_byte;
                n_busy_mode   = i_item.busy_wait;
                n_collected   = '0;
                n_poll_count  = '0;
            end
        end else begin
            unique case (r_phase)
                PH_DISCARD: begin
                    n_phase      = PH_POLL;
                    n_poll_count = '0;
                end
                PH_POLL: begin
                    n_poll_count = poll_inc[15:0];
                    if (hit) begin
                        n_collected = CW'(1);
                        if (!first_done) begin
                            n_phase = PH_COLLECT;
                        end else if (ar_emit) begin
                            n_phase = PH_IDLE;
                        end else begin
                            n_phase      = PH_BUSY;
                            n_poll_count = '0;
                        end
                    end else if (resp_expired) begin
                        n_phase = PH_IDLE;
                    end
                end
                PH_COLLECT: begin
                    n_collected = coll_inc[CW-1:0];
                    if (coll_done) begin
                        if (ar_emit) begin
                            n_phase = PH_IDLE;
                        end else begin
                            n_phase      = PH_BUSY;
                            n_poll_count = '0;
                        end
                    end
                end
                PH_BUSY: begin
                    n_poll_count = poll_inc[15:0];
                    if (busy_expired || rx != 8'd0) begin
                        n_phase = PH_IDLE;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    // results
    always_comb begin
        o_res     = '0;
        o_res_cnt = 3'd0;
        if (i_item.action == ACT_START) begin
            if (len_zero) begin
                o_res[0]  = mk_result(KIND_DONE, 8'd0, 3'd0, STATUS_OK, 1'b1);
                o_res_cnt = 3'd1;
            end else begin
                o_res[0] = mk_result(KIND_SEND, FILL_BYTE, 3'd0, 1'b0, 1'b0);
                o_res[1] = mk_result(KIND_SEND, msg[39:32], 3'd1, 1'b0, 1'b0);
                o_res[2] = mk_result(KIND_SEND, msg[31:24], 3'd2, 1'b0, 1'b0);
                o_res[3] = mk_result(KIND_SEND, msg[23:16], 3'd3, 1'b0, 1'b0);
                o_res[4] = mk_result(KIND_SEND, msg[15:8],  3'd4, 1'b0, 1'b0);
                o_res[5] = mk_result(KIND_SEND, msg[7:0],   3'd5, 1'b0, 1'b0);
                o_res[6] = mk_result(KIND_SEND, {crc, 1'b1}, 3'd6, 1'b0, 1'b1);
                o_res_cnt = 3'(FRAME_LEN);
            end
        end else begin
            unique case (r_phase)
                PH_DISCARD: begin
                    o_res[0]  = mk_result(KIND_CONSUMED, rx, 3'd0, 1'b0, 1'b1);
                    o_res_cnt = 3'd1;
                end
                PH_POLL: begin
                    if (hit) begin
                        if (first_done && ar_emit) begin
                            o_res[0]  = mk_result(KIND_RESPONSE, rx, 3'd0, 1'b0, 1'b0);
                            o_res[1]  = mk_result(KIND_DONE, 8'd0, 3'd0, r_busy_mode, 1'b1);
                            o_res_cnt = 3'd2;
                        end else begin
                            o_res[0]  = mk_result(KIND_RESPONSE, rx, 3'd0, 1'b0, 1'b1);
                            o_res_cnt = 3'd1;
                        end
                    end else if (resp_expired) begin
                        o_res[0]  = mk_result(KIND_CONSUMED, rx, 3'd0, 1'b0, 1'b0);
                        o_res[1]  = mk_result(KIND_DONE, 8'd0, 3'd0, STATUS_TIMEOUT, 1'b1);
                        o_res_cnt = 3'd2;
                    end else begin
                        o_res[0]  = mk_result(KIND_CONSUMED, rx, 3'd0, 1'b0, 1'b1);
                        o_res_cnt = 3'd1;
                    end
                end
                PH_COLLECT: begin
                    if (coll_done && ar_emit) begin
                        o_res[0]  = mk_result(KIND_RESPONSE, rx, 3'(r_collected), 1'b0, 1'b0);
                        o_res[1]  = mk_result(KIND_DONE, 8'd0, 3'd0, r_busy_mode, 1'b1);
                        o_res_cnt = 3'd2;
                    end else begin
                        o_res[0]  = mk_result(KIND_RESPONSE, rx, 3'(r_collected), 1'b0, 1'b1);
                        o_res_cnt = 3'd1;
                    end
                end
                PH_BUSY: begin
                    if (busy_expired || rx != 8'd0) begin
                        o_res[0]  = mk_result(KIND_CONSUMED, rx, 3'd0, 1'b0, 1'b0);
                        o_res[1]  = mk_result(KIND_DONE, 8'd0, 3'd0,
                                              busy_expired ? STATUS_TIMEOUT : STATUS_OK, 1'b1);
                        o_res_cnt = 3'd2;
                    end else begin
                        o_res[0]  = mk_result(KIND_CONSUMED, rx, 3'd0, 1'b0, 1'b1);
                        o_res_cnt = 3'd1;
                    end
                end
                default: begin
                    o_res_cnt = 3'd0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_poll_count  <= '0;
            r_collected   <= '0;
            r_want        <= '0;
            r_match_mode  <= 1'b0;
            r_match_value <= '0;
            r_busy_mode   <= 1'b0;
        end else if (i_advance) begin
            r_phase       <= n_phase;
            r_poll_count  <= n_poll_count;
            r_collected   <= n_collected;
            r_want        <= n_want;
            r_match_mode  <= n_match_mode;
            r_match_value <= n_match_value;
            r_busy_mode   <= n_busy_mode;
        end
    end

endmodule

`default_nettype wire

/* src/sdce_burst.sv */
// Result register: holds the results of one item and plays them out one per beat.
// Depends on sdce_pkg.
`default_nettype none

module sdce_burst
    import sdce_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_load,
    input  wire t_result [FRAME_LEN-1:0]   i_res,
    input  wire logic [2:0]                i_res_cnt,
    input  wire logic                      i_ready,
    output logic                           o_valid,
    output t_result                        o_res,
    output logic                           o_free
);

    t_result     r_res [FRAME_LEN];
    logic [2:0]  r_cnt;
    logic [2:0]  r_idx;
    logic        last_beat;

    assign o_valid   = (r_cnt != 3'd0);
    assign o_res     = r_res[r_idx];
    assign last_beat = (r_idx == r_cnt - 3'd1);
    // free now, or freed by the beat going out this cycle
    assign o_free    = !o_valid || (i_ready && last_beat);

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            for (int k = 0; k < FRAME_LEN; k++) begin
                r_res[k] <= i_res[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 3'd0;
            r_idx <= 3'd0;
        end else if (i_load) begin
            r_cnt <= i_res_cnt;
            r_idx <= 3'd0;
        end else if (o_valid && i_ready) begin
            if (last_beat) begin
                r_cnt <= 3'd0;
            end else begin
                r_idx <= r_idx + 3'd1;
            end
        end
    end

endmodule

`default_nettype wire
